// File: src/rqb_pkg.sv
// rqb_pkg: shared types, constants and arithmetic helpers of the rounded quad shade/blend unit
// no dependencies; imported by every module of the block
package rqb_pkg;

    localparam int COORD_FRAC_BITS = 4;
    localparam int DIST_SHIFT      = 12 - COORD_FRAC_BITS;
    localparam int LIN_SHIFT       = COORD_FRAC_BITS + 2;
    localparam int SQ_STEPS        = 4;
    localparam int SQ_STAGES       = 4;
    localparam int NUM_STAGES      = 18;
    localparam int FRONT_STAGES    = 2;
    localparam int SHADE_STAGES    = 10;
    localparam int BLEND_STAGES    = 2;
    localparam int CFG_IDX_W       = 3;

    localparam logic [12:0] FRAC_ONE  = 13'd4096;
    localparam logic [12:0] FRAC_HALF = 13'd2048;
    localparam logic [19:0] BLEND_DEN = 20'd1044480;
    localparam logic [27:0] HALF_DEN  = 28'd522240;
    // x / 255 as (x * K) >> 28, exact below 2^20
    localparam logic [20:0] DIV255_K  = 21'h101011;
    // x / 255 as (x * K) >> 23, exact below 2^16
    localparam logic [15:0] DIV255_K16 = 16'h8081;

    localparam logic [CFG_IDX_W-1:0] REG_GEOM   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RADII  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FILL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GRAD   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BORDER = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SHADOW = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SETUP  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RECIP  = 3'd7;

    typedef logic [3:0][7:0] rgba_t;

    typedef struct packed {
        logic [15:0]       hw;
        logic [15:0]       hh;
        logic [15:0]       blur;
        logic [15:0]       bw;
        logic [3:0][15:0]  radii;
        rgba_t             fill;
        rgba_t             grad;
        rgba_t             border;
        rgba_t             shadow;
        logic              grad_on;
        logic              radial;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic [15:0]       isw;
        logic [15:0]       r_far;
        logic [15:0]       r_blur;
        logic [15:0]       r_is;
        logic              plain;
    } cfg_t;

    typedef struct packed {
        rgba_t              dst;
        logic               pass;
        logic signed [19:0] qneg;
        logic signed [17:0] rad_r;
        logic [12:0]        t_lin;
    } side_t;

    typedef struct packed {
        logic [19:0] rem;
        logic [15:0] root;
        logic [31:0] rad;
    } sq_t;

    typedef struct packed {
        rgba_t       col;
        rgba_t       dst;
        logic [19:0] amt;
        logic        wr;
    } blend_t;

    // four digits of the restoring square root
    function automatic sq_t sq_steps(input sq_t s);
        sq_t         v;
        logic [19:0] trial;
        v = s;
        for (int i = 0; i < SQ_STEPS; i++)
        begin
            v.rem = {v.rem[17:0], v.rad[31:30]};
            v.rad = {v.rad[29:0], 2'b00};
            trial = {2'b00, v.root, 2'b01};
            if (v.rem >= trial)
            begin
                v.rem  = v.rem - trial;
                v.root = {v.root[14:0], 1'b1};
            end
            else
            begin
                v.root = {v.root[14:0], 1'b0};
            end
        end
        return v;
    endfunction

    function automatic logic [7:0] mix8(input logic [7:0] a, input logic [7:0] b,
                                        input logic [12:0] t);
        logic [21:0] acc;
        acc = 22'(a) * 22'(FRAC_ONE - t) + 22'(b) * 22'(t) + 22'(FRAC_HALF);
        return acc[19:12];
    endfunction

    function automatic logic [12:0] frac_clip(input logic [33:0] p);
        if (p[33:4] > 30'(FRAC_ONE))
            return FRAC_ONE;
        else
            return p[16:4];
    endfunction

    function automatic logic [12:0] clamp_frac(input logic signed [31:0] v);
        if (v < 0)
            return 13'd0;
        else if (v > 32'sd4096)
            return FRAC_ONE;
        else
            return v[12:0];
    endfunction

    // round(u*u*(3-2u)) with u2 = u*u precomputed
    function automatic logic [12:0] smooth(input logic [12:0] u, input logic [25:0] u2);
        logic [39:0] acc;
        acc = 40'(u2) * 40'(14'd12288 - {u, 1'b0}) + 40'd8388608;
        return acc[36:24];
    endfunction

endpackage

// File: src/rqb_front.sv
// rqb_front: input capture, squares, gradient dot product and box geometry (two stages)
// depends on rqb_pkg
module rqb_front (
    input  logic                                   clk,
    input  logic [rqb_pkg::FRONT_STAGES-1:0]       en,
    input  rqb_pkg::cfg_t                          cfg,
    input  logic signed [15:0]                     offset_x,
    input  logic signed [15:0]                     offset_y,
    input  logic [7:0]                             dst_red,
    input  logic [7:0]                             dst_green,
    input  logic [7:0]                             dst_blue,
    input  logic [7:0]                             dst_alpha,
    output rqb_pkg::sq_t                           rad_sq,
    output rqb_pkg::sq_t                           box_sq,
    output rqb_pkg::side_t                         side
);
    import rqb_pkg::*;

    logic signed [17:0] x18, y18, hw18, hh18, hwi, hhi, rmin, rsel, rr;
    logic [16:0]        ax, ay;
    logic signed [19:0] qx, qy, qmax;
    logic [1:0]         sel;

    logic [31:0]        xx_next, yy_next;
    logic signed [31:0] xc_next, yc_next;
    logic [15:0]        ox_next, oy_next;
    side_t              side0_next;

    logic [31:0]        xx_reg, yy_reg;
    logic signed [31:0] xc_reg, yc_reg;
    logic [15:0]        ox_reg, oy_reg;
    side_t              side0_reg;

    logic signed [32:0] lsum, lsh;
    logic signed [31:0] lval;
    sq_t                rad_next, box_next;
    side_t              side1_next;

    sq_t                rad_reg, box_reg;
    side_t              side1_reg;

    always_comb
    begin
        x18  = {{2{offset_x[15]}}, offset_x};
        y18  = {{2{offset_y[15]}}, offset_y};
        ax   = x18[17] ? 17'(-x18) : 17'(x18);
        ay   = y18[17] ? 17'(-y18) : 17'(y18);
        hw18 = $signed({2'b00, cfg.hw});
        hh18 = $signed({2'b00, cfg.hh});
        hwi  = hw18 - $signed({2'b00, cfg.blur});
        hhi  = hh18 - $signed({2'b00, cfg.blur});
        // corner by quadrant: ul, ur, lr, ll
        if (x18 > 0)
            sel = (y18 > 0) ? 2'd2 : 2'd1;
        else
            sel = (y18 > 0) ? 2'd3 : 2'd0;
        rsel = $signed({2'b00, cfg.radii[sel]});
        rmin = (hwi < hhi) ? hwi : hhi;
        rr   = (rsel < rmin) ? rsel : rmin;
        qx   = $signed({3'b000, ax})
             - ($signed({{2{hwi[17]}}, hwi}) - $signed({{2{rr[17]}}, rr}));
        qy   = $signed({3'b000, ay})
             - ($signed({{2{hhi[17]}}, hhi}) - $signed({{2{rr[17]}}, rr}));
        qmax = (qx > qy) ? qx : qy;
        ox_next = (qx > 0) ? qx[15:0] : 16'd0;
        oy_next = (qy > 0) ? qy[15:0] : 16'd0;

        xx_next = 32'(offset_x) * 32'(offset_x);
        yy_next = 32'(offset_y) * 32'(offset_y);
        xc_next = offset_x * cfg.cx;
        yc_next = offset_y * cfg.cy;

        side0_next.dst   = {dst_alpha, dst_blue, dst_green, dst_red};
        side0_next.pass  = (cfg.hw == 16'd0) || (cfg.hh == 16'd0) || (cfg.fill[3] == 8'd0)
                         || (x18 < -hw18) || (x18 > hw18) || (y18 < -hh18) || (y18 > hh18);
        side0_next.qneg  = (qmax < 0) ? qmax : 20'sd0;
        side0_next.rad_r = rr;
        side0_next.t_lin = 13'd0;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            xx_reg    <= xx_next;
            yy_reg    <= yy_next;
            xc_reg    <= xc_next;
            yc_reg    <= yc_next;
            ox_reg    <= ox_next;
            oy_reg    <= oy_next;
            side0_reg <= side0_next;
        end
    end

    always_comb
    begin
        // linear gradient, floor of the shifted dot product
        lsum = $signed({xc_reg[31], xc_reg}) + $signed({yc_reg[31], yc_reg});
        lsh  = lsum >>> LIN_SHIFT;
        lval = 32'(lsh) + 32'sd2048;

        rad_next.rem  = 20'd0;
        rad_next.root = 16'd0;
        rad_next.rad  = xx_reg + yy_reg;
        box_next.rem  = 20'd0;
        box_next.root = 16'd0;
        box_next.rad  = 32'(ox_reg) * 32'(ox_reg) + 32'(oy_reg) * 32'(oy_reg);

        side1_next       = side0_reg;
        side1_next.t_lin = clamp_frac(lval);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            rad_reg   <= rad_next;
            box_reg   <= box_next;
            side1_reg <= side1_next;
        end
    end

    assign rad_sq = rad_reg;
    assign box_sq = box_reg;
    assign side   = side1_reg;

endmodule

// File: src/rqb_sqrt.sv
// rqb_sqrt: pipelined restoring square root, two lanes, four digits per stage
// depends on rqb_pkg
module rqb_sqrt (
    input  logic                             clk,
    input  logic [rqb_pkg::SQ_STAGES-1:0]    en,
    input  rqb_pkg::sq_t                     a_in,
    input  rqb_pkg::sq_t                     b_in,
    input  rqb_pkg::side_t                   side_in,
    output rqb_pkg::sq_t                     a_out,
    output rqb_pkg::sq_t                     b_out,
    output rqb_pkg::side_t                   side_out
);
    import rqb_pkg::*;

    sq_t   a_reg [SQ_STAGES];
    sq_t   b_reg [SQ_STAGES];
    side_t side_reg [SQ_STAGES];
    sq_t   a_next [SQ_STAGES];
    sq_t   b_next [SQ_STAGES];
    side_t side_next [SQ_STAGES];

    always_comb
    begin
        for (int k = 0; k < SQ_STAGES; k++)
        begin
            if (k == 0)
            begin
                a_next[k]    = sq_steps(a_in);
                b_next[k]    = sq_steps(b_in);
                side_next[k] = side_in;
            end
            else
            begin
                a_next[k]    = sq_steps(a_reg[k-1]);
                b_next[k]    = sq_steps(b_reg[k-1]);
                side_next[k] = side_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < SQ_STAGES; k++)
        begin
            if (en[k])
            begin
                a_reg[k]    <= a_next[k];
                b_reg[k]    <= b_next[k];
                side_reg[k] <= side_next[k];
            end
        end
    end

    assign a_out    = a_reg[SQ_STAGES-1];
    assign b_out    = b_reg[SQ_STAGES-1];
    assign side_out = side_reg[SQ_STAGES-1];

endmodule

// File: src/rqb_shade.sv
// rqb_shade: distance, coverage, gradient, smoothstep and color mixes (ten stages)
// depends on rqb_pkg
module rqb_shade (
    input  logic                              clk,
    input  logic [rqb_pkg::SHADE_STAGES-1:0]  en,
    input  rqb_pkg::cfg_t                     cfg,
    input  rqb_pkg::sq_t                      rad_in,
    input  rqb_pkg::sq_t                      box_in,
    input  rqb_pkg::side_t                    side_in,
    output rqb_pkg::blend_t                   bl
);
    import rqb_pkg::*;

    typedef struct packed {
        side_t              side;
        logic [15:0]        rlen;
        logic signed [20:0] d;
        logic [33:0]        pr;
        logic [33:0]        pb;
        logic [33:0]        pi;
        logic [12:0]        covh;
        logic [12:0]        inner;
        logic [12:0]        tg;
        logic [12:0]        fb;
        logic [12:0]        fi;
        logic [25:0]        ub2;
        logic [25:0]        ui2;
        logic [12:0]        covb;
        logic [12:0]        tis;
        logic [19:0]        ian;
        logic [12:0]        ia;
        rgba_t              colg;
        rgba_t              cols;
        rgba_t              colb;
        rgba_t              col;
        logic [19:0]        amt;
        logic               wr;
    } shd_t;

    shd_t               st_reg [SHADE_STAGES];
    shd_t               st_next [SHADE_STAGES];
    logic [15:0]        boxr;
    logic signed [21:0] ab, nd;
    logic signed [31:0] d32, db32;
    logic [40:0]        iap;
    logic [12:0]        cov;
    rgba_t              csel;

    always_comb
    begin
        // round to nearest root, then signed box distance
        st_next[0]      = '0;
        st_next[0].side = side_in;
        st_next[0].rlen = rad_in.root + 16'(rad_in.rem > 20'(rad_in.root));
        boxr            = box_in.root + 16'(box_in.rem > 20'(box_in.root));
        st_next[0].d    = $signed({5'b00000, boxr}) + 21'(side_in.qneg)
                        - 21'(side_in.rad_r);

        // reciprocal products and hard coverage
        st_next[1] = st_reg[0];
        ab   = 22'(st_reg[0].d) + $signed({6'b000000, cfg.blur});
        nd   = -22'(st_reg[0].d);
        d32  = 32'(st_reg[0].d);
        db32 = d32 + $signed({16'h0000, cfg.bw});
        st_next[1].pr    = 34'(st_reg[0].rlen) * 34'(cfg.r_far);
        st_next[1].pb    = (ab > 0) ? 34'(ab[17:0]) * 34'(cfg.r_blur) : 34'd0;
        st_next[1].pi    = (nd > 0) ? 34'(nd[17:0]) * 34'(cfg.r_is) : 34'd0;
        st_next[1].covh  = clamp_frac(32'sd2048 - (d32 <<< DIST_SHIFT));
        st_next[1].inner = clamp_frac(32'sd2048 - (db32 <<< DIST_SHIFT));

        // fractions
        st_next[2]    = st_reg[1];
        st_next[2].tg = cfg.radial ? frac_clip(st_reg[1].pr) : st_reg[1].side.t_lin;
        st_next[2].fb = frac_clip(st_reg[1].pb);
        st_next[2].fi = frac_clip(st_reg[1].pi);

        // gradient mix and smoothstep squares
        st_next[3] = st_reg[2];
        for (int c = 0; c < 4; c++)
            st_next[3].colg[c] = cfg.grad_on ? mix8(cfg.fill[c], cfg.grad[c], st_reg[2].tg)
                                             : cfg.fill[c];
        st_next[3].ub2 = 26'(st_reg[2].fb) * 26'(st_reg[2].fb);
        st_next[3].ui2 = 26'(st_reg[2].fi) * 26'(st_reg[2].fi);

        // smoothstep
        st_next[4]      = st_reg[3];
        st_next[4].covb = FRAC_ONE - smooth(st_reg[3].fb, st_reg[3].ub2);
        st_next[4].tis  = FRAC_ONE - smooth(st_reg[3].fi, st_reg[3].ui2);

        // inner shadow amount, divided by 255 in the next stage
        st_next[5]     = st_reg[4];
        st_next[5].ian = 20'(cfg.shadow[3]) * 20'(st_reg[4].tis) + 20'd127;

        st_next[6]    = st_reg[5];
        iap           = 41'(st_reg[5].ian) * 41'(DIV255_K);
        st_next[6].ia = iap[40:28];

        // inner shadow mix, color channels only
        st_next[7]      = st_reg[6];
        st_next[7].cols = st_reg[6].colg;
        if (cfg.isw != 16'd0)
        begin
            for (int c = 0; c < 3; c++)
                st_next[7].cols[c] = mix8(st_reg[6].colg[c], cfg.shadow[c], st_reg[6].ia);
        end

        // border mix
        st_next[8] = st_reg[7];
        for (int c = 0; c < 4; c++)
            st_next[8].colb[c] = (cfg.bw != 16'd0)
                               ? mix8(cfg.border[c], st_reg[7].cols[c], st_reg[7].inner)
                               : st_reg[7].cols[c];

        // path select and source amount
        st_next[9] = st_reg[8];
        if (cfg.plain)
        begin
            csel = st_reg[8].colg;
            cov  = FRAC_ONE;
        end
        else if (cfg.blur != 16'd0)
        begin
            csel = st_reg[8].colg;
            cov  = st_reg[8].covb;
        end
        else
        begin
            csel = st_reg[8].colb;
            cov  = st_reg[8].covh;
        end
        st_next[9].col = csel;
        st_next[9].amt = 20'(csel[3]) * 20'(cov);
        st_next[9].wr  = !st_reg[8].side.pass && (st_next[9].amt != 20'd0);
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < SHADE_STAGES; k++)
        begin
            if (en[k])
                st_reg[k] <= st_next[k];
        end
    end

    assign bl.col = st_reg[SHADE_STAGES-1].col;
    assign bl.dst = st_reg[SHADE_STAGES-1].side.dst;
    assign bl.amt = st_reg[SHADE_STAGES-1].amt;
    assign bl.wr  = st_reg[SHADE_STAGES-1].wr;

endmodule

// File: src/rqb_blend.sv
// rqb_blend: source-over numerators and constant division, output register (two stages)
// depends on rqb_pkg
module rqb_blend (
    input  logic                              clk,
    input  logic [rqb_pkg::BLEND_STAGES-1:0]  en,
    input  rqb_pkg::blend_t                   bl,
    output rqb_pkg::rgba_t                    out_col,
    output logic                              written
);
    import rqb_pkg::*;

    logic [19:0]       denm;
    logic [3:0][27:0]  num_next, num_reg;
    rgba_t             dst_reg;
    logic              wr_reg;
    logic [31:0]       qp;
    rgba_t             out_next, out_reg;
    logic              wr_out_reg;

    always_comb
    begin
        denm = BLEND_DEN - bl.amt;
        for (int c = 0; c < 3; c++)
            num_next[c] = 28'(bl.col[c]) * 28'(bl.amt) + 28'(bl.dst[c]) * 28'(denm) + HALF_DEN;
        num_next[3] = 28'(8'd255) * 28'(bl.amt) + 28'(bl.dst[3]) * 28'(denm) + HALF_DEN;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            num_reg <= num_next;
            dst_reg <= bl.dst;
            wr_reg  <= bl.wr;
        end
    end

    // divide by 255 * 4096: shift, then reciprocal multiply
    always_comb
    begin
        qp = 32'd0;
        for (int c = 0; c < 4; c++)
        begin
            qp          = 32'(num_reg[c][27:12]) * 32'(DIV255_K16);
            out_next[c] = wr_reg ? qp[30:23] : dst_reg[c];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            out_reg    <= out_next;
            wr_out_reg <= wr_reg;
        end
    end

    assign out_col = out_reg;
    assign written = wr_out_reg;

endmodule

// File: src/rounded_quad_pixel_shade_blend_unit.sv
// rounded_quad_pixel_shade_blend_unit: top level, configuration registers and stage control
// depends on rqb_pkg, rqb_front, rqb_sqrt, rqb_shade, rqb_blend
//
// channel   direction  handshake               payload
// input     in         in_valid / in_ready     offset_x, offset_y, dst_red..dst_alpha
// output    out        out_valid / out_ready   out_red..out_alpha, written
// config    in         cfg_we (no wait)        cfg_index, cfg_data
//
// one word per clock sustained while out_ready is high; out_valid rises when the word reaches the output register
// the depth is set by the 16-digit square root (four stages) and the mix chain
// every stage has its own valid bit and moves when the stage after it can take
// a word, so bubbles close up and a stalled output holds without loss
// reset clears the valid bits and all configuration registers
module rounded_quad_pixel_shade_blend_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [15:0]                 offset_x,
    input  logic signed [15:0]                 offset_y,
    input  logic [7:0]                         dst_red,
    input  logic [7:0]                         dst_green,
    input  logic [7:0]                         dst_blue,
    input  logic [7:0]                         dst_alpha,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [7:0]                         out_red,
    output logic [7:0]                         out_green,
    output logic [7:0]                         out_blue,
    output logic [7:0]                         out_alpha,
    output logic                               written,
    input  logic                               cfg_we,
    input  logic [rqb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [63:0]                        cfg_data
);
    import rqb_pkg::*;

    // configuration registers
    logic [63:0] geom_reg, radii_reg;
    logic [31:0] fill_reg, grad_reg, border_reg, shadow_reg;
    logic [49:0] setup_reg;
    logic [47:0] recip_reg;
    cfg_t        cfg;

    // stage control
    logic [NUM_STAGES-1:0] vld_reg, vld_next, vld_src, en;

    sq_t    f_rad, f_box, s_rad, s_box;
    side_t  f_side, s_side;
    blend_t sh_bl;
    rgba_t  out_col;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            geom_reg   <= '0;
            radii_reg  <= '0;
            fill_reg   <= '0;
            grad_reg   <= '0;
            border_reg <= '0;
            shadow_reg <= '0;
            setup_reg  <= '0;
            recip_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GEOM:   geom_reg   <= cfg_data;
                REG_RADII:  radii_reg  <= cfg_data;
                REG_FILL:   fill_reg   <= cfg_data[31:0];
                REG_GRAD:   grad_reg   <= cfg_data[31:0];
                REG_BORDER: border_reg <= cfg_data[31:0];
                REG_SHADOW: shadow_reg <= cfg_data[31:0];
                REG_SETUP:  setup_reg  <= cfg_data[49:0];
                REG_RECIP:  recip_reg  <= cfg_data[47:0];
                default:    ;
            endcase
        end
    end

    // decoded fields; the user must keep them static while words are in flight, the block does not enforce it
    always_comb
    begin
        cfg.hw      = geom_reg[15:0];
        cfg.hh      = geom_reg[31:16];
        cfg.blur    = geom_reg[47:32];
        cfg.bw      = geom_reg[63:48];
        cfg.radii   = radii_reg;
        cfg.fill    = fill_reg;
        cfg.grad    = grad_reg;
        cfg.border  = border_reg;
        cfg.shadow  = shadow_reg;
        cfg.grad_on = setup_reg[0];
        cfg.radial  = setup_reg[1];
        cfg.cx      = $signed(setup_reg[17:2]);
        cfg.cy      = $signed(setup_reg[33:18]);
        cfg.isw     = setup_reg[49:34];
        cfg.r_far   = recip_reg[15:0];
        cfg.r_blur  = recip_reg[31:16];
        cfg.r_is    = recip_reg[47:32];
        // no corners, border, blur or inner shadow: fill straight through
        cfg.plain   = (radii_reg == 64'd0) && (geom_reg[63:48] == 16'd0)
                    && (geom_reg[47:32] == 16'd0) && (setup_reg[49:34] == 16'd0);
    end

    // a stage loads when it is empty or its word moves on this cycle
    always_comb
    begin
        en[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || out_ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
            en[i] = !vld_reg[i] || en[i+1];
        vld_src  = {vld_reg[NUM_STAGES-2:0], in_valid};
        vld_next = (en & vld_src) | (~en & vld_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[NUM_STAGES-1];

    // stages 0-1: capture, squares, gradient dot product, box geometry
    rqb_front u_front (
        .clk       (clk),
        .en        (en[FRONT_STAGES-1:0]),
        .cfg       (cfg),
        .offset_x  (offset_x),
        .offset_y  (offset_y),
        .dst_red   (dst_red),
        .dst_green (dst_green),
        .dst_blue  (dst_blue),
        .dst_alpha (dst_alpha),
        .rad_sq    (f_rad),
        .box_sq    (f_box),
        .side      (f_side)
    );

    // stages 2-5: radial and box square roots
    rqb_sqrt u_sqrt (
        .clk      (clk),
        .en       (en[FRONT_STAGES+SQ_STAGES-1:FRONT_STAGES]),
        .a_in     (f_rad),
        .b_in     (f_box),
        .side_in  (f_side),
        .a_out    (s_rad),
        .b_out    (s_box),
        .side_out (s_side)
    );

    // stages 6-15: distance, coverage, gradient and color mixes
    rqb_shade u_shade (
        .clk     (clk),
        .en      (en[FRONT_STAGES+SQ_STAGES+SHADE_STAGES-1:FRONT_STAGES+SQ_STAGES]),
        .cfg     (cfg),
        .rad_in  (s_rad),
        .box_in  (s_box),
        .side_in (s_side),
        .bl      (sh_bl)
    );

    // stages 16-17: source-over blend into the output register
    rqb_blend u_blend (
        .clk     (clk),
        .en      (en[NUM_STAGES-1:NUM_STAGES-BLEND_STAGES]),
        .bl      (sh_bl),
        .out_col (out_col),
        .written (written)
    );

    assign out_red   = out_col[0];
    assign out_green = out_col[1];
    assign out_blue  = out_col[2];
    assign out_alpha = out_col[3];

endmodule
